/* design/hpid_pkg.sv */
// hpid_pkg: widths, register indexes, mode codes and pipeline payload types
// for the heading pid block; no dependencies
package hpid_pkg;

  localparam int ANGLE_W    = 16;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int DD_W       = 19;
  localparam int OPND_W     = 19;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = GAIN_W + OPND_W;
  localparam int GAIN_FRAC  = 8;
  localparam int INC_W      = PROD_W + 2;
  localparam int INC_SH_W   = INC_W - GAIN_FRAC;
  localparam int SAT_W      = 64;
  localparam int SUM_W      = SAT_W + 2;
  localparam int POS_W      = SAT_W - GAIN_FRAC;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic MODE_INCR = 1'b0;
  localparam logic MODE_POS  = 1'b1;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RST = 32'sd128000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RST = -32'sd128000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_DRIVE_MAX,
    REG_DRIVE_MIN
  } cfg_reg_e;

  typedef struct packed {
    logic                       mode;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic signed [DRIVE_W-1:0]  drive_max;
    logic signed [DRIVE_W-1:0]  drive_min;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  e0;
    logic signed [DIFF_W-1:0] de;
    logic signed [DD_W-1:0]   dd;
    logic                     dsmall;
  } err_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  e0;
    logic signed [PROD_W-1:0] pp;
    logic signed [PROD_W-1:0] pi;
    logic signed [PROD_W-1:0] pd;
  } prod_t;

endpackage

/* design/hpid_if.sv */
// hpid_if: sample, result and configuration channel interfaces
// depends on hpid_pkg for field widths
interface hpid_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hpid_pkg::ANGLE_W-1:0]  target_angle;
  logic signed [hpid_pkg::ANGLE_W-1:0]  measured_angle;
  modport source (output valid, output target_angle, output measured_angle, input ready);
  modport sink   (input valid, input target_angle, input measured_angle, output ready);
endinterface

interface hpid_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hpid_pkg::DRIVE_W-1:0]  drive;
  logic signed [hpid_pkg::ERR_W-1:0]    heading_error;
  modport source (output valid, output drive, output heading_error, input ready);
  modport sink   (input valid, input drive, input heading_error, output ready);
endinterface

interface hpid_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hpid_pkg::CFG_IDX_W-1:0]    index;
  logic [hpid_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/hpid_cfg.sv */
// hpid_cfg: configuration register file written over the cfg channel
// depends on hpid_pkg and hpid_if
module hpid_cfg (
  input  logic            clk,
  input  logic            rst,
  hpid_cfg_if.sink        cfg,
  output hpid_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode      <= hpid_pkg::MODE_POS;
      regs.gain_p    <= '0;
      regs.gain_i    <= '0;
      regs.gain_d    <= '0;
      regs.drive_max <= hpid_pkg::DRIVE_MAX_RST;
      regs.drive_min <= hpid_pkg::DRIVE_MIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hpid_pkg::REG_MODE:      regs.mode      <= cfg.data[0];
        hpid_pkg::REG_GAIN_P:    regs.gain_p    <= cfg.data[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_GAIN_I:    regs.gain_i    <= cfg.data[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_GAIN_D:    regs.gain_d    <= cfg.data[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_DRIVE_MAX: regs.drive_max <= cfg.data[hpid_pkg::DRIVE_W-1:0];
        hpid_pkg::REG_DRIVE_MIN: regs.drive_min <= cfg.data[hpid_pkg::DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/hpid_err.sv */
// hpid_err: sample input register, wrapped heading error and error history
// depends on hpid_pkg and hpid_if
module hpid_err #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic            clk,
  input  logic            rst,
  hpid_sample_if.sink     sample,
  output logic            err_valid,
  input  logic            err_ready,
  output hpid_pkg::err_t  err
);

  localparam int WRAP_W = (ANGLE_FRAC_BITS + 11 > 18) ? ANGLE_FRAC_BITS + 11 : 18;
  localparam logic signed [WRAP_W-1:0] HALF = WRAP_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [hpid_pkg::DIFF_W-1:0] D_THR =
    hpid_pkg::DIFF_W'(1 << (ANGLE_FRAC_BITS - 1));

  logic                                   in_valid;
  logic signed [hpid_pkg::ANGLE_W-1:0]    tgt_q;
  logic signed [hpid_pkg::ANGLE_W-1:0]    meas_q;
  logic signed [hpid_pkg::ERR_W-1:0]      e_last;
  logic signed [hpid_pkg::ERR_W-1:0]      e_prev;
  logic                                   err_open;
  logic signed [WRAP_W-1:0]               d;
  logic signed [WRAP_W-1:0]               wrapped;
  logic signed [hpid_pkg::ERR_W-1:0]      e0;
  logic signed [hpid_pkg::DIFF_W-1:0]     de;
  logic signed [hpid_pkg::DD_W-1:0]       dd;

  assign err_open     = !err_valid || err_ready;
  assign sample.ready = !in_valid || err_open;

  // shortest way round the circle
  always_comb begin
    d = WRAP_W'(meas_q) - WRAP_W'(tgt_q);
    if (!tgt_q[hpid_pkg::ANGLE_W-1] && meas_q[hpid_pkg::ANGLE_W-1]) begin
      wrapped = (d > -HALF) ? d : d + HALF + HALF;
    end else if (tgt_q[hpid_pkg::ANGLE_W-1] && !meas_q[hpid_pkg::ANGLE_W-1]) begin
      wrapped = (d >= HALF) ? d - HALF - HALF : d;
    end else begin
      wrapped = d;
    end
    e0 = wrapped[hpid_pkg::ERR_W-1:0];
    de = hpid_pkg::DIFF_W'(e0) - hpid_pkg::DIFF_W'(e_last);
    dd = hpid_pkg::DD_W'(e0) - (hpid_pkg::DD_W'(e_last) <<< 1) + hpid_pkg::DD_W'(e_prev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      err_valid <= 1'b0;
      e_last    <= '0;
      e_prev    <= '0;
    end else begin
      if (sample.ready) begin
        in_valid <= sample.valid;
      end
      if (err_open) begin
        err_valid <= in_valid;
        if (in_valid) begin
          e_prev <= e_last;
          e_last <= e0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      tgt_q  <= sample.target_angle;
      meas_q <= sample.measured_angle;
    end
    if (err_open && in_valid) begin
      err.e0     <= e0;
      err.de     <= de;
      err.dd     <= dd;
      err.dsmall <= (de < D_THR) && (de > -D_THR);
    end
  end

endmodule

/* design/hpid_mul.sv */
// hpid_mul: the three gain products, selected per mode, registered
// depends on hpid_pkg
module hpid_mul (
  input  logic             clk,
  input  logic             rst,
  input  hpid_pkg::cfg_t   cfg,
  input  logic             err_valid,
  output logic             err_ready,
  input  hpid_pkg::err_t   err,
  output logic             prod_valid,
  input  logic             prod_ready,
  output hpid_pkg::prod_t  prod
);

  logic signed [hpid_pkg::OPND_W-1:0] opnd_p;
  logic signed [hpid_pkg::OPND_W-1:0] opnd_d;
  logic signed [hpid_pkg::PROD_W-1:0] pp_c;
  logic signed [hpid_pkg::PROD_W-1:0] pi_c;
  logic signed [hpid_pkg::PROD_W-1:0] pd_c;

  assign err_ready = !prod_valid || prod_ready;

  always_comb begin
    if (cfg.mode == hpid_pkg::MODE_POS) begin
      opnd_p = hpid_pkg::OPND_W'(err.e0);
      // derivative dead band
      opnd_d = err.dsmall ? hpid_pkg::OPND_W'(0) : hpid_pkg::OPND_W'(err.de);
    end else begin
      opnd_p = hpid_pkg::OPND_W'(err.de);
      opnd_d = hpid_pkg::OPND_W'(err.dd);
    end
    pp_c = cfg.gain_p * opnd_p;
    pi_c = cfg.gain_i * hpid_pkg::OPND_W'(err.e0);
    pd_c = cfg.gain_d * opnd_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (err_ready) begin
      prod_valid <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (err_ready && err_valid) begin
      prod.e0 <= err.e0;
      prod.pp <= pp_c;
      prod.pi <= pi_c;
      prod.pd <= pd_c;
    end
  end

endmodule

/* design/hpid_acc.sv */
// hpid_acc: integral accumulator, saturating sums, drive clamp and result register
// depends on hpid_pkg and hpid_if
module hpid_acc #(
  parameter int INTEGRAL_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  hpid_pkg::cfg_t   cfg,
  input  logic             prod_valid,
  output logic             prod_ready,
  input  hpid_pkg::prod_t  prod,
  hpid_result_if.source    result
);

  localparam int IW = ((INTEGRAL_BITS > hpid_pkg::PROD_W) ? INTEGRAL_BITS
                                                          : hpid_pkg::PROD_W) + 1;
  localparam int SW = hpid_pkg::SUM_W;
  localparam int DW = hpid_pkg::POS_W + 1;
  localparam logic signed [IW-1:0] IMAX = (IW'(1) <<< (INTEGRAL_BITS - 1)) - IW'(1);
  localparam logic signed [IW-1:0] IMIN = -IMAX - IW'(1);
  localparam logic signed [SW-1:0] MAX64 = (SW'(1) <<< (hpid_pkg::SAT_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MIN64 = -MAX64 - SW'(1);

  function automatic logic signed [hpid_pkg::SAT_W-1:0] sat64(
    input logic signed [SW-1:0] x
  );
    logic signed [SW-1:0] y;
    priority if (x > MAX64) begin
      y = MAX64;
    end else if (x < MIN64) begin
      y = MIN64;
    end else begin
      y = x;
    end
    return y[hpid_pkg::SAT_W-1:0];
  endfunction

  logic signed [INTEGRAL_BITS-1:0]        integral_sum;
  logic signed [INTEGRAL_BITS-1:0]        integral_next;
  logic signed [IW-1:0]                   isum;
  logic signed [hpid_pkg::INC_W-1:0]      inc_sum;

  // stage a: integral updated
  logic                                   va;
  logic signed [hpid_pkg::ERR_W-1:0]      e0_a;
  logic signed [hpid_pkg::PROD_W-1:0]     pp_a;
  logic signed [hpid_pkg::PROD_W-1:0]     pd_a;
  logic signed [hpid_pkg::INC_SH_W-1:0]   inc_a;
  logic signed [INTEGRAL_BITS-1:0]        integ_a;
  // stage b: proportional plus integral
  logic                                   vb;
  logic signed [hpid_pkg::ERR_W-1:0]      e0_b;
  logic signed [hpid_pkg::PROD_W-1:0]     pd_b;
  logic signed [hpid_pkg::INC_SH_W-1:0]   inc_b;
  logic signed [hpid_pkg::SAT_W-1:0]      s1_b;
  // stage c: positional drive before clamp
  logic                                   vc;
  logic signed [hpid_pkg::ERR_W-1:0]      e0_c;
  logic signed [hpid_pkg::INC_SH_W-1:0]   inc_c;
  logic signed [hpid_pkg::POS_W-1:0]      pos_c;
  // result register, drive also serves as the last drive
  logic                                   out_valid;
  logic signed [hpid_pkg::DRIVE_W-1:0]    drive_q;
  logic signed [hpid_pkg::ERR_W-1:0]      herr_q;

  logic                                   out_open;
  logic                                   c_open;
  logic                                   b_open;
  logic signed [hpid_pkg::SAT_W-1:0]      s1_next;
  logic signed [hpid_pkg::SAT_W-1:0]      s2_next;
  logic signed [DW-1:0]                   drv;
  logic signed [DW-1:0]                   drv_hi;
  logic signed [DW-1:0]                   drv_lo;
  logic signed [DW-1:0]                   drv_max;
  logic signed [DW-1:0]                   drv_min;

  assign out_open   = !out_valid || result.ready;
  assign c_open     = !vc || out_open;
  assign b_open     = !vb || c_open;
  assign prod_ready = !va || b_open;

  assign result.valid         = out_valid;
  assign result.drive         = drive_q;
  assign result.heading_error = herr_q;

  always_comb begin
    isum = IW'(integral_sum) + IW'(prod.pi);
    priority if (isum > IMAX) begin
      integral_next = IMAX[INTEGRAL_BITS-1:0];
    end else if (isum < IMIN) begin
      integral_next = IMIN[INTEGRAL_BITS-1:0];
    end else begin
      integral_next = isum[INTEGRAL_BITS-1:0];
    end
    inc_sum = hpid_pkg::INC_W'(prod.pp) + hpid_pkg::INC_W'(prod.pi)
            + hpid_pkg::INC_W'(prod.pd);
    s1_next = sat64(SW'(pp_a) + SW'(integ_a));
    s2_next = sat64(SW'(s1_b) + SW'(pd_b));
  end

  always_comb begin
    drv_max = DW'(cfg.drive_max);
    drv_min = DW'(cfg.drive_min);
    if (cfg.mode == hpid_pkg::MODE_POS) begin
      drv = DW'(pos_c);
    end else begin
      drv = DW'(drive_q) + DW'(inc_c);
    end
    drv_hi = (drv >= drv_max) ? drv_max : drv;
    drv_lo = (drv_hi <= drv_min) ? drv_min : drv_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      out_valid    <= 1'b0;
      integral_sum <= '0;
      drive_q      <= '0;
    end else begin
      if (prod_ready) begin
        va <= prod_valid;
        if (prod_valid && cfg.mode == hpid_pkg::MODE_POS) begin
          integral_sum <= integral_next;
        end
      end
      if (b_open) begin
        vb <= va;
      end
      if (c_open) begin
        vc <= vb;
      end
      if (out_open) begin
        out_valid <= vc;
        if (vc) begin
          drive_q <= drv_lo[hpid_pkg::DRIVE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      e0_a    <= prod.e0;
      pp_a    <= prod.pp;
      pd_a    <= prod.pd;
      inc_a   <= inc_sum[hpid_pkg::INC_W-1:hpid_pkg::GAIN_FRAC];
      integ_a <= integral_next;
    end
    if (b_open && va) begin
      e0_b  <= e0_a;
      pd_b  <= pd_a;
      inc_b <= inc_a;
      s1_b  <= s1_next;
    end
    if (c_open && vb) begin
      e0_c  <= e0_b;
      inc_c <= inc_b;
      pos_c <= s2_next[hpid_pkg::SAT_W-1:hpid_pkg::GAIN_FRAC];
    end
    if (out_open && vc) begin
      herr_q <= e0_c;
    end
  end

endmodule

/* design/heading_pid_with_angle_wrap.sv */
// heading pid controller with angle wrap, incremental or positional form
// path: a sample passes the input, error, product, a, b, c and result registers
// throughput: one sample per cycle; each pipeline stage holds under backpressure
//   and the input is refused only while every stage is full and a result waits
// reset: synchronous, clears pipeline, error history, integral, last drive
//   and loads the configuration reset values
module heading_pid_with_angle_wrap #(
  parameter int INTEGRAL_BITS   = 48,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic           clk,
  input  logic           rst,
  hpid_sample_if.sink    sample,
  hpid_result_if.source  result,
  hpid_cfg_if.sink       cfg
);

  hpid_pkg::cfg_t   cfg_q;
  logic             err_valid;
  logic             err_ready;
  hpid_pkg::err_t   err_q;
  logic             prod_valid;
  logic             prod_ready;
  hpid_pkg::prod_t  prod_q;

  hpid_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_q)
  );

  hpid_err #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_err (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .err_valid (err_valid),
    .err_ready (err_ready),
    .err       (err_q)
  );

  hpid_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .err_valid  (err_valid),
    .err_ready  (err_ready),
    .err        (err_q),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod_q)
  );

  hpid_acc #(
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_acc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod_q),
    .result     (result)
  );

`ifndef ASSERT_OFF
  ap_err_hold: assert property (@(posedge clk) disable iff (rst)
    err_valid && !err_ready |=> err_valid && $stable(err_q))
    else $error("error stage lost its item under stall");

  ap_prod_hold: assert property (@(posedge clk) disable iff (rst)
    prod_valid && !prod_ready |=> prod_valid && $stable(prod_q))
    else $error("product stage lost its item under stall");

  ap_full_only: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> err_valid && prod_valid && result.valid && !result.ready)
    else $error("sample refused while the pipeline has room");
`endif

endmodule

/* tb/tb_heading_pid_with_angle_wrap.sv */
`timescale 1ns / 1ps
// self-checking testbench for heading_pid_with_angle_wrap: directed stimulus table,
// then randomized headings and register settings scored against a cycle-free predictor
// depends on hpid_pkg, the hpid_*_if interfaces and the block itself
module tb_heading_pid_with_angle_wrap;

  localparam int ANGLE_FRAC = 7;
  localparam int INTEG_BITS = 48;
  localparam longint HALF_TURN = longint'(180) << ANGLE_FRAC;
  localparam logic [hpid_pkg::CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [hpid_pkg::CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;
  localparam int ITEMS_PER_SETTING = 160;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic signed [hpid_pkg::DRIVE_W-1:0] drive;
    logic signed [hpid_pkg::ERR_W-1:0]   heading_error;
  } drive_result_t;

  typedef struct {
    bit                                  is_cfg;
    logic [hpid_pkg::CFG_IDX_W-1:0]      idx;
    logic [hpid_pkg::CFG_DATA_W-1:0]     val;
    logic signed [hpid_pkg::ANGLE_W-1:0] tgt;
    logic signed [hpid_pkg::ANGLE_W-1:0] meas;
    bit                                  pinned;
    drive_result_t                       want;
  } dir_row_t;

  logic clk;
  logic rst;

  hpid_sample_if sample_ch ();
  hpid_result_if result_ch ();
  hpid_cfg_if    cfg_ch ();

  heading_pid_with_angle_wrap dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  hpid_pkg::cfg_t model_cfg;
  longint         err_last;
  longint         err_prev;
  longint         integ_sum;
  longint         drive_last;

  drive_result_t awaited_drives[$];
  int            fail_count;
  bit            pin_on;
  drive_result_t pin_val;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_left;
  dir_row_t      dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat_add64(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  function automatic drive_result_t next_drive(logic signed [hpid_pkg::ANGLE_W-1:0] tgt,
                                               logic signed [hpid_pkg::ANGLE_W-1:0] meas);
    longint d, e0, de, inc, dterm, sum, drv, imax, kp, ki, kd, hi, lo;
    drive_result_t r;
    d = longint'(meas) - longint'(tgt);
    if (tgt >= 0 && meas < 0)
      e0 = (d > -HALF_TURN) ? d : d + 2 * HALF_TURN;
    else if (tgt < 0 && meas >= 0)
      e0 = (d >= HALF_TURN) ? d - 2 * HALF_TURN : d;
    else
      e0 = d;
    kp = longint'($signed(model_cfg.gain_p));
    ki = longint'($signed(model_cfg.gain_i));
    kd = longint'($signed(model_cfg.gain_d));
    hi = longint'($signed(model_cfg.drive_max));
    lo = longint'($signed(model_cfg.drive_min));
    if (model_cfg.mode == hpid_pkg::MODE_INCR) begin
      inc = kp * (e0 - err_last) + ki * e0 + kd * (e0 - 2 * err_last + err_prev);
      drv = drive_last + (inc >>> hpid_pkg::GAIN_FRAC);
    end else begin
      imax = (longint'(1) <<< (INTEG_BITS - 1)) - 1;
      integ_sum = sat_add64(integ_sum, ki * e0);
      if (integ_sum > imax) integ_sum = imax;
      if (integ_sum < -imax - 1) integ_sum = -imax - 1;
      de = e0 - err_last;
      // derivative dropped under half a degree of change
      dterm = (((de < 0) ? -de : de) < (longint'(1) <<< (ANGLE_FRAC - 1))) ? 0 : kd * de;
      sum = sat_add64(sat_add64(kp * e0, integ_sum), dterm);
      drv = sum >>> hpid_pkg::GAIN_FRAC;
    end
    if (drv >= hi) drv = hi;
    if (drv <= lo) drv = lo;
    drive_last = drv;
    err_prev = err_last;
    err_last = e0;
    r.drive = drv[hpid_pkg::DRIVE_W-1:0];
    r.heading_error = e0[hpid_pkg::ERR_W-1:0];
    return r;
  endfunction

  function automatic void log_failure(string what, drive_result_t want, drive_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected drive=%0d err=%0d, got drive=%0d err=%0d", $realtime, what,
               want.drive, want.heading_error, got.drive, got.heading_error);
  endfunction

  // scoreboard: predicts on accepted samples, compares accepted results
  always @(posedge clk) begin : score
    drive_result_t want, got;
    if (rst) begin
      model_cfg  = '{mode: hpid_pkg::MODE_POS, gain_p: '0, gain_i: '0, gain_d: '0,
                     drive_max: hpid_pkg::DRIVE_MAX_RST, drive_min: hpid_pkg::DRIVE_MIN_RST};
      err_last   = 0;
      err_prev   = 0;
      integ_sum  = 0;
      drive_last = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          hpid_pkg::REG_MODE:      model_cfg.mode      = cfg_ch.data[0];
          hpid_pkg::REG_GAIN_P:    model_cfg.gain_p    = cfg_ch.data[hpid_pkg::GAIN_W-1:0];
          hpid_pkg::REG_GAIN_I:    model_cfg.gain_i    = cfg_ch.data[hpid_pkg::GAIN_W-1:0];
          hpid_pkg::REG_GAIN_D:    model_cfg.gain_d    = cfg_ch.data[hpid_pkg::GAIN_W-1:0];
          hpid_pkg::REG_DRIVE_MAX: model_cfg.drive_max = cfg_ch.data;
          hpid_pkg::REG_DRIVE_MIN: model_cfg.drive_min = cfg_ch.data;
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        want = next_drive(sample_ch.target_angle, sample_ch.measured_angle);
        awaited_drives.push_back(pin_on ? pin_val : want);
      end
      if (result_ch.valid && result_ch.ready) begin
        got.drive = result_ch.drive;
        got.heading_error = result_ch.heading_error;
        if (awaited_drives.size() == 0) begin
          log_failure("result with nothing pending", '0, got);
        end else begin
          want = awaited_drives.pop_front();
          if (got.drive !== want.drive)
            log_failure("drive mismatch", want, got);
          else if (got.heading_error !== want.heading_error)
            log_failure("heading_error mismatch", want, got);
        end
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic dir_row_t heading_row(int tgt, int meas);
    dir_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, val: '0,
          tgt: tgt[hpid_pkg::ANGLE_W-1:0], meas: meas[hpid_pkg::ANGLE_W-1:0],
          pinned: 1'b0, want: '0};
    return r;
  endfunction

  function automatic dir_row_t pinned_row(int tgt, int meas, int drv, int err);
    dir_row_t r;
    r = heading_row(tgt, meas);
    r.pinned = 1'b1;
    r.want.drive = drv;
    r.want.heading_error = err[hpid_pkg::ERR_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [hpid_pkg::CFG_IDX_W-1:0] idx,
                                       logic [hpid_pkg::CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = heading_row(0, 0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic [hpid_pkg::GAIN_W-1:0] pick_gain(bit extreme);
    if (extreme) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    case ($urandom_range(4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(4096) - 2048);
    endcase
  endfunction

  task automatic send_heading(input logic signed [hpid_pkg::ANGLE_W-1:0] tgt,
                              input logic signed [hpid_pkg::ANGLE_W-1:0] meas,
                              input bit pinned, input drive_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.target_angle   <= tgt;
    sample_ch.measured_angle <= meas;
    pin_on  = pinned;
    pin_val = want;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic write_reg(input logic [hpid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpid_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering, wait for every pending result, then let the pipeline empty
  task automatic settle();
    int n;
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    n = 0;
    while (awaited_drives.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic program_setting(input int blk);
    logic [hpid_pkg::CFG_DATA_W-1:0] hi, lo;
    write_reg(hpid_pkg::REG_MODE, blk[0] ? 32'(hpid_pkg::MODE_POS) : 32'(hpid_pkg::MODE_INCR));
    write_reg(hpid_pkg::REG_GAIN_P, 32'(signed'(pick_gain(blk == 0))));
    write_reg(hpid_pkg::REG_GAIN_I, 32'(signed'(pick_gain(blk == 0))));
    write_reg(hpid_pkg::REG_GAIN_D, 32'(signed'(pick_gain(blk == 0))));
    if (blk == 0) begin
      hi = 32'h7FFF_FFFF;
      lo = 32'h8000_0000;
    end else begin
      case ($urandom_range(5))
        0: begin
          hi = 32'h8000_0000;
          lo = 32'h7FFF_FFFF;
        end
        1: begin
          hi = $urandom;
          lo = $urandom;
        end
        2: begin
          lo = $urandom_range(200000) - 100000;
          hi = lo - $urandom_range(1000);
        end
        default: begin
          hi = $urandom_range(400000, 2000);
          lo = -$urandom_range(400000, 2000);
        end
      endcase
    end
    write_reg(hpid_pkg::REG_DRIVE_MAX, hi);
    write_reg(hpid_pkg::REG_DRIVE_MIN, lo);
    if ($urandom_range(2) == 0) write_reg($urandom_range(1) ? REG_NONE_LO : REG_NONE_HI, $urandom);
  endtask

  initial begin : stimulus
    logic signed [hpid_pkg::ANGLE_W-1:0] tgt, meas;
    int pick;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.target_angle = '0;
    sample_ch.measured_angle = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    fail_count = 0;
    pin_on = 1'b0;
    pin_val = '0;
    send_idle_pct = 10;
    recv_idle_pct = 63;
    hold_left = 0;
    tgt = '0;
    meas = '0;

    // reset settings: zero gains give zero drive, errors readable directly
    dir_rows.push_back(pinned_row(0, 0, 0, 0));
    dir_rows.push_back(pinned_row(23040, -23040, 0, 0));
    dir_rows.push_back(pinned_row(-23040, 23040, 0, 0));
    dir_rows.push_back(pinned_row(0, 23040, 0, 23040));
    dir_rows.push_back(pinned_row(0, -23040, 0, 23040));
    dir_rows.push_back(pinned_row(100, -100, 0, -200));
    dir_rows.push_back(pinned_row(-100, 100, 0, 200));
    dir_rows.push_back(pinned_row(32767, -32768, 0, -19455));
    dir_rows.push_back(pinned_row(-32768, 32767, 0, 19455));
    dir_rows.push_back(pinned_row(-32768, 0, 0, -13312));
    dir_rows.push_back(pinned_row(0, -32768, 0, 13312));
    dir_rows.push_back(pinned_row(32767, 0, 0, -32767));
    dir_rows.push_back(pinned_row(-32768, -1, 0, 32767));
    // extreme gains and limits, positional
    dir_rows.push_back(reg_row(hpid_pkg::REG_GAIN_P, 32'h0000_7FFF));
    dir_rows.push_back(reg_row(hpid_pkg::REG_GAIN_I, 32'hFFFF_8000));
    dir_rows.push_back(reg_row(hpid_pkg::REG_GAIN_D, 32'h0000_0100));
    dir_rows.push_back(reg_row(hpid_pkg::REG_DRIVE_MAX, 32'h7FFF_FFFF));
    dir_rows.push_back(reg_row(hpid_pkg::REG_DRIVE_MIN, 32'h8000_0000));
    dir_rows.push_back(heading_row(0, 200));
    dir_rows.push_back(heading_row(0, 230));
    dir_rows.push_back(heading_row(0, -20000));
    // incremental, then writes to unused indexes that must not touch mode
    dir_rows.push_back(reg_row(hpid_pkg::REG_MODE, 32'(hpid_pkg::MODE_INCR)));
    dir_rows.push_back(heading_row(1000, -1000));
    dir_rows.push_back(heading_row(-23040, 23040));
    dir_rows.push_back(reg_row(REG_NONE_LO, 32'h0000_0001));
    dir_rows.push_back(reg_row(REG_NONE_HI, 32'hFFFF_FFFF));
    dir_rows.push_back(heading_row(5, 5));
    // crossed limits force drive_min
    dir_rows.push_back(reg_row(hpid_pkg::REG_DRIVE_MAX, -32'sd5));
    dir_rows.push_back(reg_row(hpid_pkg::REG_DRIVE_MIN, 32'sd5));
    dir_rows.push_back(pinned_row(300, 0, 5, -300));
    dir_rows.push_back(pinned_row(0, 300, 5, 300));
    dir_rows.push_back(reg_row(hpid_pkg::REG_DRIVE_MAX, 32'(hpid_pkg::DRIVE_MAX_RST)));
    dir_rows.push_back(reg_row(hpid_pkg::REG_DRIVE_MIN, 32'(hpid_pkg::DRIVE_MIN_RST)));
    dir_rows.push_back(reg_row(hpid_pkg::REG_MODE, 32'(hpid_pkg::MODE_POS)));
    dir_rows.push_back(heading_row(0, 100));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_heading(dir_rows[i].tgt, dir_rows[i].meas, dir_rows[i].pinned, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        settle();
        program_setting(blk);
        // long result stall so the pipeline fills and backs up the input
        if (blk == 1 && ph != 1) hold_left = 400;
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          pick = $urandom_range(9);
          case (pick)
            0: begin
              tgt = hpid_pkg::ANGLE_W'($urandom);
              meas = hpid_pkg::ANGLE_W'($urandom);
            end
            1: begin
              tgt = hpid_pkg::ANGLE_W'(($urandom_range(1) ? 23040 : -23040)
                                       + $urandom_range(16) - 8);
              meas = hpid_pkg::ANGLE_W'(($urandom_range(1) ? 23040 : -23040)
                                        + $urandom_range(16) - 8);
            end
            2, 3: begin
              meas = hpid_pkg::ANGLE_W'(meas + $urandom_range(160) - 80);
            end
            default: begin
              tgt = hpid_pkg::ANGLE_W'($urandom_range(46080) - 23040);
              meas = hpid_pkg::ANGLE_W'($urandom_range(46080) - 23040);
            end
          endcase
          send_heading(tgt, meas, 1'b0, '0);
        end
      end
    end

    settle();
    if (awaited_drives.size() != 0) log_failure("results never arrived", awaited_drives[0], '0);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
